// ===== rtl/set_median_finder_defines.svh =====
// Assertion macros for the median finder.
`ifndef SET_MEDIAN_FINDER_DEFINES_SVH
`define SET_MEDIAN_FINDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("median finder assertion failed");
`define SMF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("median finder assertion failed");
`else
`define SMF_ASSERT(lbl, prop)
`define SMF_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/set_med_pkg.sv =====
package set_med_pkg;

  localparam int unsigned COUNT_BITS = 7;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_NEXT,
    RD_MID_HI,
    RD_MID_LO
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    set_ovf;
    logic    shift;
    logic    place;
    logic    capture;
    logic    emit;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic fill_zero;
    logic pos_is_one;
    logic greater;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/set_median_finder.sv =====
// Median finder: samples of a set arrive one per transaction and are insertion-sorted
// into an on-chip store of MAX_SAMPLES entries; the transaction flagged by last_i closes
// the set and yields one result with twice the median (sum of the two middle entries for
// an even count), the number of samples kept and an overflow flag for samples dropped
// because the store was full. A kept sample is moved down past the k stored entries larger
// than it (k at most the current fill), one compare-and-move per cycle through the single
// store read port, and then written; a dropped sample only sets the overflow flag, and the
// closing sample then reads the two middle entries. Input is taken again while a result
// waits on the output register. The set is empty again after each result.
`include "set_median_finder_defines.svh"

module set_median_finder #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [SAMPLE_BITS:0]                median_x2_o,
  output logic [set_med_pkg::COUNT_BITS-1:0]  count_o,
  output logic                                overflow_o
);
  import set_med_pkg::*;

  cmd_t cmd;
  sts_t sts;

  set_med_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  set_med_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_x2_o (median_x2_o),
    .count_o     (count_o),
    .overflow_o  (overflow_o)
  );

  `SMF_ASSERT(a_no_write_when_full, cmd.place |-> !sts.full)
  `SMF_ASSERT(a_shift_only_larger, cmd.shift |-> sts.greater)
  `SMF_ASSERT(a_no_result_overwrite, sts.out_busy |-> !cmd.emit)
  `SMF_ASSERT(a_one_action, $onehot0({cmd.load, cmd.set_ovf, cmd.shift, cmd.place, cmd.emit}))
  `SMF_ASSERT_NEXT(a_emit_shows_result, cmd.emit, out_valid_o)

endmodule

// ===== rtl/set_med_ram.sv =====
module set_med_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/set_med_ctrl.sv =====
module set_med_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_ready_o,
  input  set_med_pkg::sts_t   sts_i,
  output set_med_pkg::cmd_t   cmd_o
);
  import set_med_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_PLACE = 3'd2;
  localparam logic [2:0] ST_MED0  = 3'd3;
  localparam logic [2:0] ST_MED1  = 3'd4;
  localparam logic [2:0] ST_MED2  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       last_q, last_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    last_d        = last_q;
    cmd_o         = '0;
    cmd_o.rd_sel  = RD_PREV;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = last_i;
          if (sts_i.full) begin
            cmd_o.set_ovf = 1'b1;
            state_d       = last_i ? ST_MED0 : ST_IDLE;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = sts_i.fill_zero ? ST_PLACE : ST_CMP;
          end
        end
      end
      ST_CMP: begin
        cmd_o.rd_sel = RD_NEXT;
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          if (sts_i.pos_is_one) begin
            state_d = ST_PLACE;
          end
        end else begin
          cmd_o.place = 1'b1;
          state_d     = last_q ? ST_MED0 : ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = last_q ? ST_MED0 : ST_IDLE;
      end
      ST_MED0: begin
        cmd_o.rd_sel = RD_MID_HI;
        state_d      = ST_MED1;
      end
      ST_MED1: begin
        cmd_o.rd_sel  = RD_MID_LO;
        cmd_o.capture = 1'b1;
        state_d       = ST_MED2;
      end
      ST_MED2: begin
        cmd_o.rd_sel = RD_MID_LO;
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== rtl/set_med_dp.sv =====
module set_med_dp #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  set_med_pkg::cmd_t                   cmd_i,
  output set_med_pkg::sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [SAMPLE_BITS:0]                median_x2_o,
  output logic [set_med_pkg::COUNT_BITS-1:0]  count_o,
  output logic                                overflow_o
);
  import set_med_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [CNT_W-1:0]       fill_q, fill_d;
  logic                   ovf_q, ovf_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [SAMPLE_BITS-1:0] acc_q;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS:0]   median_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic                   overflow_q;

  logic [IDX_W-1:0]       raddr, mid_hi, mid_lo;
  logic [SAMPLE_BITS-1:0] rdata;
  logic                   we;
  logic [SAMPLE_BITS-1:0] wdata;
  logic [SAMPLE_BITS:0]   sum;

  assign mid_hi = IDX_W'(fill_q >> 1);
  assign mid_lo = fill_q[0] ? mid_hi : mid_hi - IDX_W'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV:   raddr = IDX_W'(fill_q - CNT_W'(1));
      RD_NEXT:   raddr = pos_q - IDX_W'(2);
      RD_MID_HI: raddr = mid_hi;
      RD_MID_LO: raddr = mid_lo;
      default:   raddr = mid_hi;
    endcase
  end

  assign we    = cmd_i.shift || cmd_i.place;
  assign wdata = cmd_i.shift ? rdata : sample_q;

  set_med_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sum = {acc_q[SAMPLE_BITS-1], acc_q} + {rdata[SAMPLE_BITS-1], rdata};

  assign sts_o.full       = (fill_q == CNT_W'(MAX_SAMPLES));
  assign sts_o.fill_zero  = (fill_q == '0);
  assign sts_o.pos_is_one = (pos_q == IDX_W'(1));
  assign sts_o.greater    = $signed(rdata) > $signed(sample_q);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  always_comb begin
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      sample_d = sample_i;
      pos_d    = IDX_W'(fill_q);
    end
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.shift) begin
      pos_d = pos_q - IDX_W'(1);
    end
    if (cmd_i.place) begin
      fill_d = fill_q + CNT_W'(1);
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      fill_d      = '0;
      ovf_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    sample_q <= sample_d;
    if (cmd_i.capture) begin
      acc_q <= rdata;
    end
    if (cmd_i.emit) begin
      median_q   <= sum;
      count_q    <= COUNT_BITS'(fill_q);
      overflow_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_x2_o = median_q;
  assign count_o     = count_q;
  assign overflow_o  = overflow_q;

endmodule
